[hdl/eds_pkg.sv]
// Package for the edit distance engine.
// Holds the item types, the wave control type, field widths and default sizes.
// No dependencies.
`default_nettype none

package eds_pkg;

  localparam int unsigned QueryMaxDef  = 32;
  localparam int unsigned TargetMaxDef = 1023;
  localparam int unsigned SymW         = 8;
  localparam int unsigned DistW        = 10;

  localparam logic OpQuery  = 1'b0;
  localparam logic OpTarget = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [SymW-1:0] symbol;
    logic            first;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             query_truncated;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last;
    logic [SymW-1:0] symbol;
  } wave_ctl_t;

endpackage

`default_nettype wire

[hdl/eds_cell.sv]
// One cell of the edit distance row: holds one query character and one cost.
// Depends on eds_pkg for the wave control type.
`default_nettype none

module eds_cell #(
  parameter int unsigned CostW     = 10,
  parameter int unsigned Index     = 1,
  parameter int unsigned TargetMax = 1023
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    active_i,
  input  wire logic                    wr_en_i,
  input  wire logic [eds_pkg::SymW-1:0] wr_symbol_i,
  input  wire eds_pkg::wave_ctl_t      ctl_i,
  input  wire logic [CostW-1:0]        left_i,
  input  wire logic [CostW-1:0]        diag_i,
  output eds_pkg::wave_ctl_t           ctl_o,
  output logic [CostW-1:0]             left_o,
  output logic [CostW-1:0]             diag_o
);
  import eds_pkg::*;

  localparam int unsigned InitCost = (Index > TargetMax) ? TargetMax : Index;

  logic [SymW-1:0]  char_q;
  logic [CostW-1:0] cost_q, cost_d;
  logic [CostW-1:0] up;
  logic [CostW:0]   via_up, via_left, via_diag, min_ab, min_all;
  logic             mismatch;
  wave_ctl_t        ctl_q;
  logic [CostW-1:0] left_q, left_d, diag_q, diag_d;

  always_comb begin
    up       = ctl_i.first ? CostW'(InitCost) : cost_q;
    mismatch = (char_q != ctl_i.symbol);
    via_up   = {1'b0, up} + (CostW+1)'(1);
    via_left = {1'b0, left_i} + (CostW+1)'(1);
    via_diag = {1'b0, diag_i} + {{CostW{1'b0}}, mismatch};
    min_ab   = (via_up < via_left) ? via_up : via_left;
    min_all  = (min_ab < via_diag) ? min_ab : via_diag;
    if (min_all > (CostW+1)'(TargetMax)) begin
      cost_d = CostW'(TargetMax);
    end else begin
      cost_d = min_all[CostW-1:0];
    end
    left_d = active_i ? cost_d : left_i;
    diag_d = active_i ? up : diag_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      char_q <= wr_symbol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= '0;
      ctl_q  <= '0;
    end else begin
      if (ctl_i.valid && active_i) begin
        cost_q <= cost_d;
      end
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    diag_q <= diag_d;
  end

  assign ctl_o  = ctl_q;
  assign left_o = left_q;
  assign diag_o = diag_q;

endmodule

`default_nettype wire

[hdl/edit_distance_engine.sv]
// Top level of the edit distance engine: query loading, target row control
// and the chain of eds_cell instances. Depends on eds_pkg and eds_cell.
//
// Use: an item on item_i is taken at a rising edge with start high and busy
// low. A query item (operation 0) stores one query character; first clears
// the query, characters beyond QUERY_MAX are dropped and set query_truncated.
// A target item (operation 1) starts a wave that runs down the row of
// QUERY_MAX cells, one cell per cycle, updating one row of the distance table.
// busy stays high while the wave runs through the wave register and the cell
// chain, so no new item is taken until it is through; the length of the cell
// chain sets how long that is. For a target item with last set, done_o pulses
// for one cycle with result_o in the cycle in which busy falls; a new item may
// be taken at the edge that ends that cycle. The receiver cannot stall: each
// result is shown for exactly one cycle. Reset clears the query length, the
// truncation flag, the target count and all row costs; stored query
// characters are undefined until written.
`default_nettype none

module edit_distance_engine #(
  parameter int unsigned QUERY_MAX  = eds_pkg::QueryMaxDef,
  parameter int unsigned TARGET_MAX = eds_pkg::TargetMaxDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire eds_pkg::in_item_t item_i,
  output logic                   done_o,
  output eds_pkg::out_item_t     result_o
);
  import eds_pkg::*;

  localparam int unsigned LenW  = $clog2(QUERY_MAX + 1);
  localparam int unsigned CostW = $clog2(TARGET_MAX + 1);

  logic [LenW-1:0]  query_len_q, query_len_d, len_eff;
  logic             trunc_q, trunc_d;
  logic [CostW-1:0] tcount_q, tcount_d;
  logic [CostW:0]   tcount_inc;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic             take, take_query, take_target;

  wave_ctl_t        ctl_w  [0:QUERY_MAX];
  logic [CostW-1:0] left_w [0:QUERY_MAX];
  logic [CostW-1:0] diag_w [0:QUERY_MAX];
  wave_ctl_t        wave_ctl_q, wave_ctl_d;
  logic [CostW-1:0] wave_left_q, wave_diag_q;
  logic [QUERY_MAX-1:0] wr_en, active;
  logic [CostW+DistW-1:0] dist_ext;

  assign busy        = (cnt_q != '0);
  assign take        = start && !busy;
  assign take_query  = take && (item_i.operation == OpQuery);
  assign take_target = take && (item_i.operation == OpTarget);
  assign len_eff     = item_i.first ? '0 : query_len_q;

  always_comb begin
    query_len_d = query_len_q;
    trunc_d     = item_i.first ? 1'b0 : trunc_q;
    if (len_eff < LenW'(QUERY_MAX)) begin
      query_len_d = len_eff + LenW'(1);
    end else begin
      query_len_d = len_eff;
      trunc_d     = 1'b1;
    end
  end

  always_comb begin
    tcount_inc = {1'b0, (item_i.first ? {CostW{1'b0}} : tcount_q)} + (CostW+1)'(1);
    if (tcount_inc > (CostW+1)'(TARGET_MAX)) begin
      tcount_d = CostW'(TARGET_MAX);
    end else begin
      tcount_d = tcount_inc[CostW-1:0];
    end
    wave_ctl_d.valid  = take_target;
    wave_ctl_d.first  = item_i.first;
    wave_ctl_d.last   = item_i.last;
    wave_ctl_d.symbol = item_i.symbol;
    cnt_d = take_target ? LenW'(QUERY_MAX) : (busy ? cnt_q - LenW'(1) : cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_len_q <= '0;
      trunc_q     <= 1'b0;
      tcount_q    <= '0;
      cnt_q       <= '0;
      wave_ctl_q  <= '0;
    end else begin
      if (take_query) begin
        query_len_q <= query_len_d;
        trunc_q     <= trunc_d;
      end
      if (take_target) begin
        tcount_q <= tcount_d;
      end
      cnt_q      <= cnt_d;
      wave_ctl_q <= wave_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_target) begin
      wave_left_q <= tcount_d;
      wave_diag_q <= item_i.first ? '0 : tcount_q;
    end
  end

  assign ctl_w[0]  = wave_ctl_q;
  assign left_w[0] = wave_left_q;
  assign diag_w[0] = wave_diag_q;

  for (genvar k = 0; k < QUERY_MAX; k++) begin : g_cell
    assign wr_en[k]  = take_query && (len_eff == LenW'(k)) && (len_eff < LenW'(QUERY_MAX));
    assign active[k] = (LenW'(k + 1) <= query_len_q);

    eds_cell #(
      .CostW     (CostW),
      .Index     (k + 1),
      .TargetMax (TARGET_MAX)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .active_i    (active[k]),
      .wr_en_i     (wr_en[k]),
      .wr_symbol_i (item_i.symbol),
      .ctl_i       (ctl_w[k]),
      .left_i      (left_w[k]),
      .diag_i      (diag_w[k]),
      .ctl_o       (ctl_w[k+1]),
      .left_o      (left_w[k+1]),
      .diag_o      (diag_w[k+1])
    );
  end

  assign dist_ext = {{DistW{1'b0}}, left_w[QUERY_MAX]};

  assign done_o                   = ctl_w[QUERY_MAX].valid && ctl_w[QUERY_MAX].last;
  assign result_o.distance        = dist_ext[DistW-1:0];
  assign result_o.query_truncated = trunc_q;

endmodule

`default_nettype wire
